// ----- hw/rtl/exchange_field_accumulate_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the exchange field accumulator
// Shared concurrent property wrappers, clocked on aclk, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef EXCHANGE_FIELD_ACCUMULATE_ASSERT_SVH
`define EXCHANGE_FIELD_ACCUMULATE_ASSERT_SVH

// same-cycle implication
`define EFA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/efa_pkg.sv -----
// ---------------------------------------------------------------------------
// efa_pkg
// Types and constants shared by the exchange field accumulator modules.
// ---------------------------------------------------------------------------
`default_nettype none

package efa_pkg;

    localparam int NUM_SITES_DEF = 4096;

    localparam int SITE_W   = 12;
    localparam int SPIN_W   = 16;
    localparam int MOM_W    = 16;
    localparam int STR_W    = 24;
    localparam int FIELD_W  = 40;
    localparam int PROD1_W  = SPIN_W + STR_W;      // spin * strength
    localparam int PROD_W   = 64;                  // spin * strength * scale
    localparam int DIVD_W   = 62;                  // rounded dividend magnitude
    localparam int DVSR_W   = 48;                  // moment divisor
    localparam int CNT_W    = 6;
    localparam int S_DATA_W = 240;
    localparam int M_DATA_W = 136;

    // configuration register indexes
    localparam logic CFG_NORMALIZE = 1'b0;
    localparam logic CFG_SCALE     = 1'b1;

    localparam logic ACT_PRELOAD = 1'b0;
    localparam logic ACT_PATH    = 1'b1;

    localparam logic [1:0] SKIP_NONE = 2'd0;
    localparam logic [1:0] SKIP_SRC  = 2'd1;
    localparam logic [1:0] SKIP_TGT  = 2'd2;

    typedef struct packed {
        logic             load_in;
        logic             mod_step;
        logic             load_pre;
        logic             ram_rd;
        logic             load_field;
        logic             mul_a;
        logic             mul_b;
        logic             div_init;
        logic             div_step;
        logic             acc;
        logic             ram_wr;
        logic             load_out;
        logic [1:0]       comp;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic       action;
        logic [1:0] skip_now;
        logic       out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/efa_ram.sv -----
// ---------------------------------------------------------------------------
// efa_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module efa_ram #(
    parameter int WIDTH = 120,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/efa_ctrl.sv -----
// ---------------------------------------------------------------------------
// efa_ctrl
// Sequencer: site reduction, preload or store read, per-component multiply
// and divide, accumulate, write back and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module efa_ctrl
    import efa_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MOD  = 4'd1;
    localparam logic [3:0] ST_PRE  = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_RDW  = 4'd4;
    localparam logic [3:0] ST_MULA = 4'd5;
    localparam logic [3:0] ST_MULB = 4'd6;
    localparam logic [3:0] ST_DVI  = 4'd7;
    localparam logic [3:0] ST_DIV  = 4'd8;
    localparam logic [3:0] ST_ACC  = 4'd9;
    localparam logic [3:0] ST_WR   = 4'd10;
    localparam logic [3:0] ST_OUT  = 4'd11;

    localparam logic [CNT_W-1:0] MOD_LAST = CNT_W'(SITE_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIVD_W - 1);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       comp_reg, comp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        cmd.cnt    = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    cnt_next    = MOD_LAST;
                    state_next  = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = (sts.action == ACT_PRELOAD) ? ST_PRE : ST_RD;
                end
            end
            ST_PRE: begin
                cmd.load_pre = 1'b1;
                state_next   = ST_WR;
            end
            ST_RD: begin
                cmd.ram_rd = 1'b1;
                state_next = ST_RDW;
            end
            ST_RDW: begin
                cmd.load_field = 1'b1;
                comp_next      = 2'd0;
                state_next     = (sts.skip_now == SKIP_NONE) ? ST_MULA : ST_OUT;
            end
            ST_MULA: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MULB;
            end
            ST_MULB: begin
                cmd.mul_b  = 1'b1;
                state_next = ST_DVI;
            end
            ST_DVI: begin
                cmd.div_init = 1'b1;
                cnt_next     = DIV_LAST;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                if (comp_reg == 2'd2) begin
                    state_next = ST_WR;
                end else begin
                    comp_next  = comp_reg + 1'b1;
                    state_next = ST_MULA;
                end
            end
            ST_WR: begin
                cmd.ram_wr = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/efa_dp.sv -----
// ---------------------------------------------------------------------------
// efa_dp
// Datapath: item and config registers, field store, multipliers, shared
// radix-2 divider, saturating accumulate and output register.
// ---------------------------------------------------------------------------
`default_nettype none

module efa_dp
    import efa_pkg::*;
#(
    parameter int NUM_SITES = NUM_SITES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    output sts_t                     sts,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tuser,
    input  wire logic                s_tlast,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_index,
    input  wire logic [STR_W-1:0]    cfg_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic [1:0]               m_tuser,
    output logic                     m_tlast
);

    localparam int AW    = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
    localparam int MOD_W = SITE_W + 21;
    localparam logic [MOD_W-1:0] NS_EXT = MOD_W'(NUM_SITES);

    // config
    logic                    norm_reg;
    logic signed [STR_W-1:0] gs_reg;

    // captured item
    logic                      act_reg;
    logic [SITE_W-1:0]         site_reg;
    logic signed [SPIN_W-1:0]  sp_reg [3];
    logic [MOM_W-1:0]          sm_reg, tm_reg;
    logic signed [STR_W-1:0]   st_reg;
    logic signed [FIELD_W-1:0] pre_reg [3];
    logic                      last_reg;

    // working
    logic signed [FIELD_W-1:0] field_reg [3];
    logic signed [PROD1_W-1:0] prod1_reg;
    logic signed [PROD_W-1:0]  p_reg;
    logic [DVSR_W-1:0]         d_reg;
    logic                      neg_reg;
    logic [DIVD_W-1:0]         quo_reg;
    logic [DVSR_W:0]           rem_reg;
    logic [1:0]                skip_reg;

    logic                      m_tvalid_reg;
    logic [M_DATA_W-1:0]       m_tdata_reg;
    logic [1:0]                m_tuser_reg;
    logic                      m_tlast_reg;

    logic [3*FIELD_W-1:0] ram_rdata;
    logic [3*FIELD_W-1:0] ram_wdata;
    logic [AW-1:0]        ram_addr;

    logic [MOD_W-1:0]            mod_diff;
    logic [2*MOM_W-1:0]          mm;
    logic [PROD_W-1:0]           mag;
    logic [DVSR_W:0]             div_sh;
    logic [DVSR_W:0]             div_sub;
    logic signed [PROD_W-1:0]    inc;
    logic signed [PROD_W-1:0]    sum;
    logic signed [FIELD_W-1:0]   sat;
    logic [1:0]                  skip_now;

    localparam logic signed [PROD_W-1:0] FMAX = PROD_W'({1'b0, {(FIELD_W-1){1'b1}}});
    localparam logic signed [PROD_W-1:0] FMIN = -FMAX - 64'sd1;

    assign mod_diff = {21'b0, site_reg} - (NS_EXT << cmd.cnt[3:0]);
    assign mm       = sm_reg * tm_reg;
    // sign taken from the product itself, neg_reg is loaded on the same edge
    assign mag      = p_reg[PROD_W-1] ? (PROD_W'(0) - p_reg) : p_reg;
    assign div_sh   = {rem_reg[DVSR_W-1:0], quo_reg[DIVD_W-1]};
    assign div_sub  = div_sh - {1'b0, d_reg};
    assign inc      = neg_reg ? -$signed({2'b0, quo_reg}) : $signed({2'b0, quo_reg});
    assign sum      = PROD_W'(field_reg[cmd.comp]) + inc;
    assign sat      = (sum > FMAX) ? FMAX[FIELD_W-1:0] :
                      (sum < FMIN) ? FMIN[FIELD_W-1:0] : sum[FIELD_W-1:0];

    always_comb begin
        priority if (sm_reg == '0) begin
            skip_now = SKIP_SRC;
        end else if (norm_reg && tm_reg == '0) begin
            skip_now = SKIP_TGT;
        end else begin
            skip_now = SKIP_NONE;
        end
    end

    assign sts.action   = act_reg;
    assign sts.skip_now = skip_now;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign ram_addr  = AW'(site_reg);
    assign ram_wdata = {field_reg[2], field_reg[1], field_reg[0]};

    efa_ram #(
        .WIDTH (3*FIELD_W),
        .DEPTH (NUM_SITES)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.ram_wr),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_reg <= 1'b1;
            gs_reg   <= 24'sd65536;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NORMALIZE: norm_reg <= cfg_data[0];
                CFG_SCALE:     gs_reg   <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            act_reg    <= s_tuser;
            site_reg   <= s_tdata[11:0];
            sp_reg[0]  <= $signed(s_tdata[27:12]);
            sp_reg[1]  <= $signed(s_tdata[43:28]);
            sp_reg[2]  <= $signed(s_tdata[59:44]);
            sm_reg     <= s_tdata[75:60];
            tm_reg     <= s_tdata[91:76];
            st_reg     <= $signed(s_tdata[115:92]);
            pre_reg[0] <= $signed(s_tdata[155:116]);
            pre_reg[1] <= $signed(s_tdata[195:156]);
            pre_reg[2] <= $signed(s_tdata[235:196]);
            last_reg   <= s_tlast;
        end
        // one restoring step of the site reduction
        if (cmd.mod_step && !mod_diff[MOD_W-1]) begin
            site_reg <= mod_diff[SITE_W-1:0];
        end
        if (cmd.load_pre) begin
            field_reg <= pre_reg;
            skip_reg  <= SKIP_NONE;
        end
        if (cmd.load_field) begin
            field_reg[0] <= $signed(ram_rdata[FIELD_W-1:0]);
            field_reg[1] <= $signed(ram_rdata[2*FIELD_W-1:FIELD_W]);
            field_reg[2] <= $signed(ram_rdata[3*FIELD_W-1:2*FIELD_W]);
            skip_reg     <= skip_now;
        end
        if (cmd.mul_a) begin
            prod1_reg <= sp_reg[cmd.comp] * st_reg;
            d_reg     <= norm_reg ? {1'b0, mm, 15'b0} : {9'b0, sm_reg, 23'b0};
        end
        if (cmd.mul_b) begin
            p_reg   <= prod1_reg * gs_reg;
        end
        if (cmd.div_init) begin
            neg_reg <= p_reg[PROD_W-1];
            quo_reg <= mag[DIVD_W-1:0] + {15'b0, d_reg[DVSR_W-1:1]};
            rem_reg <= '0;
        end
        if (cmd.div_step) begin
            if (!div_sub[DVSR_W]) begin
                rem_reg <= div_sub;
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b1};
            end else begin
                rem_reg <= div_sh;
                quo_reg <= {quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
        if (cmd.acc) begin
            field_reg[cmd.comp] <= sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tdata_reg <= {4'b0, field_reg[2], field_reg[1], field_reg[0], site_reg};
            m_tuser_reg <= skip_reg;
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/exchange_field_accumulate.sv -----
// ---------------------------------------------------------------------------
// exchange_field_accumulate
// Spin-exchange field accumulator over a per-site store of Q24.16 fields.
// ---------------------------------------------------------------------------
// Input stream (s_*): one item per path or preload; tuser = action,
// tlast = last_path. Output stream (m_*): one result per item; tuser =
// skipped code, tlast = sweep_done.
// Config channel (cfg_*): index 0 normalize_moments, 1 scale; always
// ready, write only while no item is in flight.
// Each item first runs 12 steps of site reduction modulo NUM_SITES; a preload
// then writes the store, a skipped path goes straight to the output, and an
// applied path runs the shared radix-2 divider, 62 steps for each of the three
// field components. One item in flight at a time; s_tready returns in the
// cycle after the result loads, so no new item is taken before the last
// result has been loaded into the output register.
// Reset: config returns to normalize 1, scale 1.0; the field store is not
// cleared and must be preloaded before a site is accumulated.
// Stall: a finished result sits in the output register; the next item may be
// accepted meanwhile, and its result waits until the register empties.
// ---------------------------------------------------------------------------
`default_nettype none

module exchange_field_accumulate
    import efa_pkg::*;
#(
    parameter int NUM_SITES = NUM_SITES_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // to_site, source_x, source_y, source_z, source_moment, target_moment,
    // strength, preload_x, preload_y, preload_z
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic                s_tuser,  // action
    input  wire logic                s_tlast,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [STR_W-1:0]    cfg_data,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // site, field_x, field_y, field_z
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic [1:0]               m_tuser,  // skipped
    output logic                     m_tlast
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    efa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    efa_dp #(
        .NUM_SITES (NUM_SITES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`include "exchange_field_accumulate_assert.svh"

    `EFA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted while busy")
    `EFA_ASSERT_SAME(a_out_load_free, cmd.load_out, !m_tvalid || m_tready, "result overwritten")
    `EFA_ASSERT_SAME(a_skip_code, m_tvalid, m_tuser != 2'd3, "bad skip code")
    `EFA_ASSERT_SAME(a_no_out_load_idle, s_tready, !cmd.load_out, "result without item")

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: exchange field accumulator testbench
// Streams preload and path items into the block and scores each result
// against a typed expectation or a bit-true prediction of the field store.
// Configuration covers both normalization modes and the extremes of the
// scale. Both stream sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import efa_pkg::*;

    localparam int  N_SITES   = 4096;
    localparam int  N_PHASES  = 6;
    localparam int  PHASE_LEN = 165;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam longint FMAX = 64'sd549755813887;
    localparam longint FMIN = -64'sd549755813888;

    typedef struct {
        logic               action;
        logic [11:0]        site;
        logic signed [15:0] sx, sy, sz;
        logic [15:0]        ms, mt;
        logic signed [23:0] st;
        logic signed [39:0] px, py, pz;
        logic               last;
    } ex_item_t;

    typedef struct {
        logic [11:0]        site;
        logic signed [39:0] fx, fy, fz;
        logic [1:0]         skip;
        logic               done;
    } field_res_t;

    typedef struct {
        ex_item_t   it;
        bit         typed;
        field_res_t res;
    } dir_row_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tlast = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [STR_W-1:0]    cfg_data = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [1:0]          m_tuser;
    logic                m_tlast;

    exchange_field_accumulate uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predicted state
    longint             fld [N_SITES][3];
    bit                 written [N_SITES];
    bit                 norm_mode;
    logic signed [23:0] gscale;

    field_res_t fields_due[$];
    int  n_errors, n_results, n_paths, n_preloads, n_skips, n_sats;
    bit  quiet;
    longint cycles;

    function automatic longint sat40(longint v);
        if (v > FMAX) return FMAX;
        if (v < FMIN) return FMIN;
        return v;
    endfunction

    function automatic field_res_t accumulate_field(ex_item_t it);
        field_res_t r;
        int site;
        longint spin [3];
        longint p, q, sum;
        longint unsigned d, mag;
        site = it.site % N_SITES;
        r.skip = SKIP_NONE;
        spin[0] = it.sx; spin[1] = it.sy; spin[2] = it.sz;
        if (it.action == ACT_PRELOAD) begin
            fld[site][0] = it.px; fld[site][1] = it.py; fld[site][2] = it.pz;
            written[site] = 1'b1;
        end else if (it.ms == 0) begin
            r.skip = SKIP_SRC;
        end else if (norm_mode && it.mt == 0) begin
            r.skip = SKIP_TGT;
        end else begin
            d = norm_mode ? ({48'd0, it.ms} * {48'd0, it.mt}) << 15 : {48'd0, it.ms} << 23;
            for (int k = 0; k < 3; k++) begin
                p = spin[k] * longint'(it.st) * longint'(gscale);
                mag = (p < 0) ? -p : p;
                q = (mag + d / 2) / d;
                sum = fld[site][k] + ((p < 0) ? -q : q);
                if (sum != sat40(sum)) n_sats++;
                fld[site][k] = sat40(sum);
            end
        end
        r.site = 12'(site);
        r.fx = 40'(fld[site][0]); r.fy = 40'(fld[site][1]); r.fz = 40'(fld[site][2]);
        r.done = it.last;
        return r;
    endfunction

    task automatic send_item(ex_item_t it, bit typed, field_res_t typed_res);
        field_res_t r;
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.action;
        s_tlast  <= it.last;
        s_tdata  <= {4'd0, it.pz, it.py, it.px, it.st, it.mt, it.ms,
                     it.sz, it.sy, it.sx, it.site};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = accumulate_field(it);
        if (it.action == ACT_PRELOAD) n_preloads++; else n_paths++;
        if (r.skip != SKIP_NONE) n_skips++;
        fields_due.insert(fields_due.size(), typed ? typed_res : r);
    endtask

    task automatic write_cfg(logic idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_NORMALIZE) norm_mode = val[0];
        else gscale = val;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (fields_due.size() > 0) @(posedge aclk);
        repeat (250) @(posedge aclk);
    endtask

    function automatic ex_item_t rand_item();
        ex_item_t it;
        int w;
        it.action = ($urandom_range(0, 99) < 15) ? ACT_PRELOAD : ACT_PATH;
        it.sx = 16'($urandom); it.sy = 16'($urandom); it.sz = 16'($urandom);
        case ($urandom_range(0, 9))
            0: it.ms = 16'd0;
            1: it.ms = 16'($urandom_range(1, 255));
            default: it.ms = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0: it.mt = 16'd0;
            1: it.mt = 16'($urandom_range(1, 255));
            default: it.mt = 16'($urandom);
        endcase
        it.st = 24'($urandom);
        if ($urandom_range(0, 1)) begin
            it.px = 40'({$urandom, $urandom}); it.py = 40'({$urandom, $urandom});
            it.pz = 40'({$urandom, $urandom});
        end else begin
            it.px = $signed(24'($urandom)); it.py = $signed(24'($urandom));
            it.pz = $signed(24'($urandom));
        end
        it.last = ($urandom_range(0, 7) == 0);
        // paths only hit sites that hold a preloaded field
        if (it.action == ACT_PRELOAD) begin
            it.site = 12'($urandom);
        end else begin
            do w = $urandom_range(0, N_SITES - 1); while (!written[w]);
            it.site = 12'(w);
        end
        return it;
    endfunction

    // result side: random stall bursts and scoring
    int stall_left = 0;
    always @(posedge aclk) begin
        field_res_t e, a;
        if (aresetn && m_tvalid && m_tready) begin
            a.site = m_tdata[11:0];
            a.fx = m_tdata[51:12]; a.fy = m_tdata[91:52]; a.fz = m_tdata[131:92];
            a.skip = m_tuser; a.done = m_tlast;
            n_results++;
            if (fields_due.size() == 0) begin
                $error("unexpected result item, site %0d", a.site);
                n_errors++;
            end else begin
                e = fields_due.pop_front();
                if (a.site != e.site) begin
                    $error("site: expected %0d actual %0d", e.site, a.site); n_errors++;
                end
                if (a.fx != e.fx) begin
                    $error("field_x: expected %0d actual %0d", e.fx, a.fx); n_errors++;
                end
                if (a.fy != e.fy) begin
                    $error("field_y: expected %0d actual %0d", e.fy, a.fy); n_errors++;
                end
                if (a.fz != e.fz) begin
                    $error("field_z: expected %0d actual %0d", e.fz, a.fz); n_errors++;
                end
                if (a.skip != e.skip) begin
                    $error("skipped: expected %0d actual %0d", e.skip, a.skip); n_errors++;
                end
                if (a.done != e.done) begin
                    $error("sweep_done: expected %0d actual %0d", e.done, a.done); n_errors++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && aresetn && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic ex_item_t mk(logic act, logic [11:0] site, logic signed [15:0] sx,
                                    logic [15:0] ms, logic [15:0] mt, logic signed [23:0] st,
                                    logic signed [39:0] pv, logic last);
        ex_item_t it;
        it.action = act; it.site = site;
        it.sx = sx; it.sy = -sx; it.sz = sx >>> 3;
        it.ms = ms; it.mt = mt; it.st = st;
        it.px = pv; it.py = pv; it.pz = pv; it.last = last;
        return it;
    endfunction

    function automatic field_res_t fres(logic [11:0] site, longint v, logic [1:0] skip,
                                        logic done);
        field_res_t r;
        r.site = site; r.fx = 40'(v); r.fy = 40'(v); r.fz = 40'(v);
        r.skip = skip; r.done = done;
        return r;
    endfunction

    initial begin
        dir_row_t rows[$];
        field_res_t none;
        logic [23:0] scales [N_PHASES];
        cycles = 0; n_errors = 0; n_results = 0; quiet = 0;
        n_paths = 0; n_preloads = 0; n_skips = 0; n_sats = 0;
        norm_mode = 1'b1; gscale = 24'sd65536;
        none = fres(0, 0, SKIP_NONE, 0);

        // typed rows: preload echoes, skips, saturation at both ends
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PRELOAD, 0, 0, 0, 0, 0, 40'(FMAX), 0), 1,
                         fres(0, FMAX, SKIP_NONE, 0)});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PRELOAD, 4095, 0, 0, 0, 0, 40'(FMIN), 1),
                         1, fres(4095, FMIN, SKIP_NONE, 1)});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PRELOAD, 5, 0, 0, 0, 0, 0, 0), 1,
                         fres(5, 0, SKIP_NONE, 0)});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 0, 16'sd32767, 0, 65535,
                         24'sd8388607, 0, 0), 1, fres(0, FMAX, SKIP_SRC, 0)});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 4095, -16'sd32768, 1, 0, 24'sd100,
                         0, 1), 1, fres(4095, FMIN, SKIP_TGT, 1)});
        // all three spin components negative with negative strength: every
        // increment is positive
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 0, -16'sd32768, 1, 1,
                         -24'sd8388608, 0, 0), 1, fres(0, FMAX, SKIP_NONE, 0)});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 4095, -16'sd32768, 1, 1,
                         24'sd8388607, 0, 0), 1, fres(4095, FMIN, SKIP_NONE, 0)});
        // predicted rows
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 5, 16'sd12345, 16'h0100, 16'h0100,
                         24'sd65536, 0, 0), 0, none});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 5, -16'sd32768, 65535, 65535,
                         -24'sd8388608, 0, 1), 0, none});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 5, 16'sd32767, 16'h0180, 16'h0001,
                         24'sd3, 0, 0), 0, none});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 5, -16'sd1, 16'h0001, 16'h0001,
                         -24'sd1, 0, 0), 0, none});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PRELOAD, 2730, 0, 0, 0, 0,
                         40'sh5555555555, 1), 0, none});
        rows.insert(rows.size(), dir_row_t'{mk(ACT_PATH, 2730, 16'sh5555, 16'haaaa, 16'h5555,
                         24'sh555555, 0, 0), 0, none});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);
        drain();

        scales[0] = 24'sd65536;   scales[1] = 24'sh800000; scales[2] = 24'sh7fffff;
        scales[3] = 24'd0;        scales[4] = 24'($urandom); scales[5] = 24'sd32768;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_cfg(CFG_NORMALIZE, {23'd0, ph[0]});
            write_cfg(CFG_SCALE, scales[ph]);
            quiet = (ph == N_PHASES - 1);
            repeat (PHASE_LEN) send_item(rand_item(), 0, none);
            drain();
        end

        $display("covered %0d preloads, %0d paths (%0d skipped, %0d saturating components)",
                 n_preloads, n_paths, n_skips, n_sats);
        $display("%0d results checked over both normalization modes and %0d scales",
                 n_results, N_PHASES);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/efa_pkg.sv
hw/rtl/efa_ram.sv
hw/rtl/efa_ctrl.sv
hw/rtl/efa_dp.sv
hw/rtl/exchange_field_accumulate.sv
dv/tb.sv
